// File: rtl/brq_pkg.sv
package brq_pkg;

	localparam int CW = 9;   // capacity and fill count width

	typedef enum logic [2:0] {
		ACT_APPEND  = 3'd0,
		ACT_GET     = 3'd1,
		ACT_DEQUEUE = 3'd2,
		ACT_PEEK    = 3'd3,
		ACT_BAPPEND = 3'd4,
		ACT_BPEEK   = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_EMPTY  = 2'd1,
		STS_RANGE  = 2'd2,
		STS_NOROOM = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	typedef struct packed {
		logic [2:0]    action;
		logic [7:0]    data_in;
		logic [7:0]    amount;
		logic [CW-1:0] block_length;
		logic          block_first;
		logic [6:0]    peek_size;
	} in_item_t;

	typedef struct packed {
		logic [7:0]    data_out;
		logic [1:0]    status;
		logic [CW-1:0] fill_count;
		logic          is_empty;
		logic          last;
	} out_item_t;

endpackage

// File: rtl/brq_chan_if.sv
interface brq_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/byte_ring_queue_with_peek.sv
// Byte ring queue with a run-time capacity (register written over cfg, values
// of zero act as one, values above DEPTH act as DEPTH; every write empties the
// queue) and random-access peek. Each request on req is one action: append,
// get, dequeue n, peek at offset, block append element, block peek. Append,
// dequeue, block append, failed checks, zero-size block peeks and unused codes
// load their response directly, so such requests can run back to back while
// rsp keeps taking results. Get and single peek first issue the read of the
// byte store and then load its registered data. A block peek of n bytes issues
// one store read per byte, streamed with last on the final byte. The store has
// a single read port. One response register sits on rsp; a stalled rsp holds
// the block and every read in flight.
module byte_ring_queue_with_peek
	import brq_pkg::*;
#(
	parameter int DEPTH    = 256,
	parameter int MAX_PEEK = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	brq_chan_if.sink   cfg,
	brq_chan_if.sink   req,
	brq_chan_if.source rsp
);
	localparam int PW = $clog2(DEPTH);
	// arithmetic width: room for a pointer plus an offset, or count plus length
	localparam int AW = ((PW > CW) ? PW : CW) + 1;
	localparam int RW = $clog2(MAX_PEEK + 1);

	// queue control state
	logic [PW-1:0] head_q, tail_q;
	logic [CW-1:0] cnt_q, cap_q;
	logic          acc_q;
	state_t        state_q;

	// read sequencer for get and peeks
	logic [PW-1:0] rp_q;
	logic [RW-1:0] rem_q;
	logic [CW-1:0] pend_fill_q;

	// response register
	logic      out_valid_q;
	out_item_t out_q;

	logic [PW-1:0] head_nxt, tail_nxt, rp_nxt;
	logic [CW-1:0] cnt_nxt, pend_fill_nxt;
	logic          acc_nxt;
	state_t        state_nxt;
	logic [RW-1:0] rem_nxt;
	logic          load_out;
	out_item_t     out_nxt;

	logic          ram_we, ram_re;
	logic [PW-1:0] ram_ra;
	logic [7:0]    ram_rdata;

	logic          can_load, in_acc;
	in_item_t      it;
	logic [AW-1:0] cap_eff, cnt_a, amt_a, blen_a, win_a;
	logic [PW-1:0] head_inc, tail_inc, head_amt, rp_inc;
	logic [6:0]    psize_cl;

	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] p, input logic [AW-1:0] c);
		return (p >= c) ? p - c : p;
	endfunction

	assign it       = req.payload;
	assign cfg.ready = 1'b1;
	assign can_load = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && can_load;
	assign in_acc   = req.valid && req.ready;

	// clamp capacity into one to DEPTH
	assign cap_eff = (cap_q == '0) ? AW'(1) :
		((AW'(cap_q) > AW'(DEPTH)) ? AW'(DEPTH) : AW'(cap_q));
	assign cnt_a  = AW'(cnt_q);
	assign amt_a  = AW'(it.amount);
	assign blen_a = (it.block_length == '0) ? AW'(1) : AW'(it.block_length);

	// all sums stay below twice the capacity, so one subtract wraps them
	assign head_inc = PW'(wrap(AW'(head_q) + AW'(1), cap_eff));
	assign tail_inc = PW'(wrap(AW'(tail_q) + AW'(1), cap_eff));
	assign head_amt = PW'(wrap(AW'(head_q) + amt_a, cap_eff));
	assign rp_inc   = PW'(wrap(AW'(rp_q) + AW'(1), cap_eff));

	assign psize_cl = (it.peek_size > 7'(MAX_PEEK)) ? 7'(MAX_PEEK) : it.peek_size;
	assign win_a    = amt_a + AW'(psize_cl);

	always_comb begin
		head_nxt      = head_q;
		tail_nxt      = tail_q;
		cnt_nxt       = cnt_q;
		acc_nxt       = acc_q;
		state_nxt     = state_q;
		rp_nxt        = rp_q;
		rem_nxt       = rem_q;
		pend_fill_nxt = pend_fill_q;
		load_out      = 1'b0;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		ram_ra        = head_q;
		out_nxt.data_out   = '0;
		out_nxt.status     = STS_OK;
		out_nxt.last       = 1'b1;
		out_nxt.fill_count = '0;
		out_nxt.is_empty   = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					load_out = 1'b1;
					unique case (it.action)
						ACT_APPEND: begin
							// overwrite the oldest byte when full, head follows
							ram_we   = 1'b1;
							tail_nxt = tail_inc;
							if (cnt_a < cap_eff)
								cnt_nxt = cnt_q + CW'(1);
							else
								head_nxt = head_inc;
						end
						ACT_GET: begin
							if (cnt_q == '0) begin
								out_nxt.status = STS_EMPTY;
							end else begin
								// pop now, deliver the byte once the store answers
								load_out      = 1'b0;
								ram_re        = 1'b1;
								ram_ra        = head_q;
								head_nxt      = head_inc;
								cnt_nxt       = cnt_q - CW'(1);
								pend_fill_nxt = cnt_q - CW'(1);
								rem_nxt       = RW'(1);
								state_nxt     = S_READ;
							end
						end
						ACT_DEQUEUE: begin
							if (amt_a > cnt_a) begin
								out_nxt.status = STS_EMPTY;
							end else begin
								cnt_nxt  = cnt_q - CW'(it.amount);
								head_nxt = head_amt;
							end
						end
						ACT_PEEK: begin
							if (amt_a >= cnt_a) begin
								out_nxt.status = STS_RANGE;
							end else begin
								load_out      = 1'b0;
								ram_re        = 1'b1;
								ram_ra        = head_amt;
								rp_nxt        = head_amt;
								pend_fill_nxt = cnt_q;
								rem_nxt       = RW'(1);
								state_nxt     = S_READ;
							end
						end
						ACT_BAPPEND: begin
							// first element checks room for the whole block
							if (it.block_first ? (cnt_a + blen_a <= cap_eff) :
								(acc_q && (cnt_a < cap_eff))) begin
								acc_nxt  = 1'b1;
								ram_we   = 1'b1;
								tail_nxt = tail_inc;
								cnt_nxt  = cnt_q + CW'(1);
							end else begin
								acc_nxt        = 1'b0;
								out_nxt.status = STS_NOROOM;
							end
						end
						ACT_BPEEK: begin
							if (win_a > cnt_a) begin
								out_nxt.status = STS_RANGE;
							end else if (psize_cl != '0) begin
								load_out      = 1'b0;
								ram_re        = 1'b1;
								ram_ra        = head_amt;
								rp_nxt        = head_amt;
								pend_fill_nxt = cnt_q;
								rem_nxt       = RW'(psize_cl);
								state_nxt     = S_READ;
							end
						end
						default: begin
						end
					endcase
				end
				out_nxt.fill_count = cnt_nxt;
				out_nxt.is_empty   = (cnt_nxt == '0);
			end
			S_READ: begin
				// registered read data holds while rsp stalls
				out_nxt.data_out   = ram_rdata;
				out_nxt.fill_count = pend_fill_q;
				out_nxt.is_empty   = (pend_fill_q == '0);
				out_nxt.last       = (rem_q == RW'(1));
				if (can_load) begin
					load_out = 1'b1;
					if (rem_q == RW'(1)) begin
						state_nxt = S_IDLE;
					end else begin
						// advance to the next byte of the block peek
						ram_re  = 1'b1;
						ram_ra  = rp_inc;
						rp_nxt  = rp_inc;
						rem_nxt = rem_q - RW'(1);
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			cnt_q   <= '0;
			acc_q   <= 1'b0;
			cap_q   <= CW'(256);
			state_q <= S_IDLE;
		end else if (cfg.valid) begin
			// new capacity empties the queue; store contents stay
			cap_q   <= cfg.payload;
			head_q  <= '0;
			tail_q  <= '0;
			cnt_q   <= '0;
			acc_q   <= 1'b0;
			state_q <= S_IDLE;
		end else begin
			head_q  <= head_nxt;
			tail_q  <= tail_nxt;
			cnt_q   <= cnt_nxt;
			acc_q   <= acc_nxt;
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		rp_q        <= rp_nxt;
		rem_q       <= rem_nxt;
		pend_fill_q <= pend_fill_nxt;
		if (load_out)
			out_q <= out_nxt;
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	// writes land at the edge; any read is issued at a later edge, so no bypass
	brq_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata(it.data_in),
		.re   (ram_re),
		.raddr(ram_ra),
		.rdata(ram_rdata)
	);
endmodule

// File: rtl/brq_ram.sv
module brq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench
	import brq_pkg::*;
();

	localparam int unsigned DEPTH    = 256;
	localparam int unsigned MAX_PEEK = 64;

	// action codes the block treats as no-ops
	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;

	// Shadow of the ring: byte store, pointers, fill count and the open-block
	// flag, plus the responses each accepted request is due to produce.
	class ring_shadow;
		logic [7:0]    mem [DEPTH];
		logic [CW-1:0] capacity;
		int unsigned   head, tail, count;
		bit            blk_open;
		out_item_t     due_rsp [$];
		int unsigned   mismatches, requests, responses;

		function new();
			capacity   = 9'd256;
			mismatches = 0;
			requests   = 0;
			responses  = 0;
			clear();
		endfunction

		function void clear();
			head     = 0;
			tail     = 0;
			count    = 0;
			blk_open = 1'b0;
		endfunction

		function void set_capacity(logic [CW-1:0] v);
			capacity = v;
			clear();
		endfunction

		// capacity as the ring actually uses it
		function int unsigned span();
			if (capacity == 0) return 1;
			if (capacity > DEPTH) return DEPTH;
			return capacity;
		endfunction

		function int unsigned wrap(int unsigned p);
			int unsigned c;
			c = span();
			return (p >= c) ? p - c : p;
		endfunction

		function void push_rsp(logic [7:0] d, status_t s, bit fin);
			out_item_t r;
			r.data_out   = d;
			r.status     = s;
			r.fill_count = CW'(count);
			r.is_empty   = (count == 0);
			r.last       = fin;
			due_rsp.push_back(r);
		endfunction

		function void apply_request(in_item_t it);
			int unsigned c, n, sz, i;
			bit          ok;
			logic [7:0]  rd;
			c = span();
			requests++;
			case (it.action)
				ACT_APPEND: begin
					mem[tail] = it.data_in;
					tail = wrap(tail + 1);
					if (count < c) count++;
					else head = wrap(head + 1);
					push_rsp(8'd0, STS_OK, 1'b1);
				end
				ACT_GET: begin
					if (count == 0) begin
						push_rsp(8'd0, STS_EMPTY, 1'b1);
					end else begin
						rd = mem[head];
						head = wrap(head + 1);
						count--;
						push_rsp(rd, STS_OK, 1'b1);
					end
				end
				ACT_DEQUEUE: begin
					if (it.amount > count) begin
						push_rsp(8'd0, STS_EMPTY, 1'b1);
					end else begin
						count -= it.amount;
						head = wrap(head + it.amount);
						push_rsp(8'd0, STS_OK, 1'b1);
					end
				end
				ACT_PEEK: begin
					if (it.amount >= count) push_rsp(8'd0, STS_RANGE, 1'b1);
					else push_rsp(mem[wrap(head + it.amount)], STS_OK, 1'b1);
				end
				ACT_BAPPEND: begin
					if (it.block_first) begin
						n = (it.block_length == 0) ? 1 : it.block_length;
						ok = (count + n <= c);
					end else begin
						ok = blk_open && (count < c);
					end
					if (ok) begin
						blk_open = 1'b1;
						mem[tail] = it.data_in;
						tail = wrap(tail + 1);
						count++;
						push_rsp(8'd0, STS_OK, 1'b1);
					end else begin
						blk_open = 1'b0;
						push_rsp(8'd0, STS_NOROOM, 1'b1);
					end
				end
				ACT_BPEEK: begin
					sz = (it.peek_size > MAX_PEEK) ? MAX_PEEK : it.peek_size;
					if (it.amount + sz > count) begin
						push_rsp(8'd0, STS_RANGE, 1'b1);
					end else if (sz == 0) begin
						push_rsp(8'd0, STS_OK, 1'b1);
					end else begin
						for (i = 0; i < sz; i++)
							push_rsp(mem[wrap(head + it.amount + i)], STS_OK, i + 1 == sz);
					end
				end
				default: push_rsp(8'd0, STS_OK, 1'b1);
			endcase
		endfunction

		function void check_response(out_item_t got);
			out_item_t want;
			responses++;
			if (due_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("response %0d arrived with nothing due: %s %02h %0d %0d",
						responses, "data/status/fill", got.data_out, got.status,
						got.fill_count);
				return;
			end
			want = due_rsp.pop_front();
			if (got.data_out !== want.data_out || got.status !== want.status ||
			    got.fill_count !== want.fill_count || got.is_empty !== want.is_empty ||
			    got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("response %0d: want d=%02h st=%0d fill=%0d empty=%0b last=%0b",
						responses, want.data_out, want.status, want.fill_count,
						want.is_empty, want.last);
					$display("              got  d=%02h st=%0d fill=%0d empty=%0b last=%0b",
						got.data_out, got.status, got.fill_count, got.is_empty, got.last);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   burst;   // when set, neither side inserts idle cycles
	int unsigned settings;

	ring_shadow shadow = new();

	brq_chan_if #(.T(logic [CW-1:0])) cfg_ch ();
	brq_chan_if #(.T(in_item_t))      req_ch ();
	brq_chan_if #(.T(out_item_t))     rsp_ch ();

	byte_ring_queue_with_peek #(
		.DEPTH   (DEPTH),
		.MAX_PEEK(MAX_PEEK)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case a request or a response never completes
	initial begin
		#10_000_000;
		$display("timeout with %0d responses still due", shadow.due_rsp.size());
		$display("[byte_ring_queue_with_peek] ERROR");
		$finish;
	end

	// Check every accepted response against the oldest one still due. Values
	// read right after the edge are the ones the block saw at that edge.
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready)
			shadow.check_response(rsp_ch.payload);
	end

	// Response side: hold ready low for a random stall, possibly none, before taking
	// each response, never while a burst phase runs.
	initial begin : rsp_pacing
		int unsigned stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	function automatic in_item_t make_item(logic [2:0] act, logic [7:0] d, logic [7:0] amt,
	                                       logic [CW-1:0] blen, logic first, logic [6:0] psz);
		in_item_t it;
		it.action       = act;
		it.data_in      = d;
		it.amount       = amt;
		it.block_length = blen;
		it.block_first  = first;
		it.peek_size    = psz;
		return it;
	endfunction

	// every field random over its full width
	function automatic in_item_t noise_item();
		return make_item(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
			9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
			7'($urandom_range(0, 127)));
	endfunction

	function automatic int unsigned at_most(int unsigned v, int unsigned lim);
		return (v > lim) ? lim : v;
	endfunction

	// Hold off a random gap, then present the request until the block takes
	// it; record it in the shadow at the accepting edge.
	task automatic send_request(in_item_t it);
		int unsigned gap;
		gap = burst ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= it;
		do @(posedge clk); while (!req_ch.ready);
		shadow.apply_request(it);
	endtask

	// Drain every due response first, so the write lands on an idle block.
	task automatic write_capacity(logic [CW-1:0] v);
		req_ch.valid <= 1'b0;
		while (shadow.due_rsp.size() != 0) @(negedge clk);
		@(posedge clk);
		cfg_ch.valid   <= 1'b1;
		cfg_ch.payload <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		shadow.set_capacity(v);
		settings++;
	endtask

	initial begin : stimulus
		in_item_t      it;
		logic [CW-1:0] caps [9];
		int unsigned   budgets [9];
		int unsigned   ph, sent, c, room, len, tails, k, pick, cnt, avail;

		// drive every input to a known value from time zero
		req_ch.valid   <= 1'b0;
		req_ch.payload <= '0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.payload <= '0;
		settings = 0;
		burst    = 1'b0;
		arst_n   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at the reset capacity, starting from an empty ring.
		// empty get, peek past count, drop nothing, drop too many
		send_request(make_item(ACT_GET,     8'h00, 8'd0,   9'd0,   1'b0, 7'd0));
		send_request(make_item(ACT_PEEK,    8'h00, 8'd0,   9'd0,   1'b0, 7'd0));
		send_request(make_item(ACT_DEQUEUE, 8'h00, 8'd0,   9'd0,   1'b0, 7'd0));
		send_request(make_item(ACT_DEQUEUE, 8'h00, 8'd1,   9'd0,   1'b0, 7'd0));
		// zero-size block peek, then one beyond the fill
		send_request(make_item(ACT_BPEEK,   8'h00, 8'd0,   9'd0,   1'b0, 7'd0));
		send_request(make_item(ACT_BPEEK,   8'h00, 8'd0,   9'd0,   1'b0, 7'd1));
		send_request(make_item(ACT_APPEND,  8'h00, 8'd0,   9'd0,   1'b0, 7'd0));
		send_request(make_item(ACT_APPEND,  8'hff, 8'd0,   9'd0,   1'b0, 7'd0));
		send_request(make_item(ACT_APPEND,  8'ha5, 8'd0,   9'd0,   1'b0, 7'd0));
		send_request(make_item(ACT_APPEND,  8'h5a, 8'd0,   9'd0,   1'b0, 7'd0));
		// last entry, offset equal to count, far offset
		send_request(make_item(ACT_PEEK,    8'h00, 8'd3,   9'd0,   1'b0, 7'd0));
		send_request(make_item(ACT_PEEK,    8'h00, 8'd4,   9'd0,   1'b0, 7'd0));
		send_request(make_item(ACT_PEEK,    8'h00, 8'd255, 9'd0,   1'b0, 7'd0));
		// whole ring, then a size that clamps to the maximum
		send_request(make_item(ACT_BPEEK,   8'h00, 8'd0,   9'd0,   1'b0, 7'd4));
		send_request(make_item(ACT_BPEEK,   8'h00, 8'd1,   9'd0,   1'b0, 7'd127));
		send_request(make_item(ACT_GET,     8'h00, 8'd0,   9'd0,   1'b0, 7'd0));
		send_request(make_item(ACT_DEQUEUE, 8'h00, 8'd255, 9'd0,   1'b0, 7'd0));
		send_request(make_item(ACT_DEQUEUE, 8'h00, 8'd2,   9'd0,   1'b0, 7'd0));
		// block of three
		send_request(make_item(ACT_BAPPEND, 8'h11, 8'd0,   9'd3,   1'b1, 7'd0));
		send_request(make_item(ACT_BAPPEND, 8'h22, 8'd0,   9'd0,   1'b0, 7'd0));
		send_request(make_item(ACT_BAPPEND, 8'h33, 8'd0,   9'd0,   1'b0, 7'd0));
		// zero length acts as one; no room for a block; rejected block's tail
		send_request(make_item(ACT_BAPPEND, 8'h44, 8'd0,   9'd0,   1'b1, 7'd0));
		send_request(make_item(ACT_BAPPEND, 8'h55, 8'd0,   9'd256, 1'b1, 7'd0));
		send_request(make_item(ACT_BAPPEND, 8'h66, 8'd0,   9'd0,   1'b0, 7'd0));
		send_request(make_item(ACT_SPARE6,  8'h00, 8'd0,   9'd0,   1'b0, 7'd0));
		send_request(make_item(ACT_SPARE7,  8'hff, 8'hff,  9'h1ff, 1'b1, 7'h7f));

		// Capacity settings: the one-entry ring (written as one and as zero),
		// the out-of-range values that clamp to the store depth, small rings that
		// wrap and overwrite often, and the full store depth itself.
		caps    = '{9'd1, 9'd0, 9'd511, 9'd5, 9'd2, 9'd3, 9'd257, 9'd256, 9'd41};
		budgets = '{12, 10, 20, 20, 12, 24, 12, 20, 20};
		caps[5] = 9'($urandom_range(3, 40));
		caps[8] = 9'($urandom_range(41, 255));

		for (ph = 0; ph < 9; ph++) begin
			write_capacity(caps[ph]);
			burst = (ph % 3 == 1);

			// At the clamped depth, fill the whole store with one block sized to it,
			// then push one element too many.
			if (caps[ph] == 9'd511) begin
				for (k = 0; k <= DEPTH; k++) begin
					it = noise_item();
					it.action       = ACT_BAPPEND;
					it.block_first  = (k == 0);
					it.block_length = 9'(DEPTH);
					send_request(it);
				end
			end

			sent = 0;
			while (sent < budgets[ph]) begin
				c    = shadow.span();
				cnt  = shadow.count;
				it   = noise_item();
				pick = $urandom_range(0, 99);
				if (pick < 22) begin
					it.action = ACT_APPEND;
				end else if (pick < 32) begin
					it.action = ACT_GET;
				end else if (pick < 42) begin
					// mostly drop up to half of what is there (rounded up), now and then a random amount
					it.action = ACT_DEQUEUE;
					if ($urandom_range(0, 3) != 0)
						it.amount = 8'($urandom_range(0, at_most((cnt + 1) / 2, 255)));
				end else if (pick < 52) begin
					it.action = ACT_PEEK;
					if (cnt != 0 && $urandom_range(0, 4) != 0)
						it.amount = 8'($urandom_range(0, at_most(cnt - 1, 255)));
				end else if (pick < 70) begin
					// Block append: a head element with its length, then the rest of
					// the block; sometimes oversized, sometimes overrun by a few.
					room = c - cnt;
					if (room != 0 && $urandom_range(0, 5) != 0)
						len = $urandom_range(1, at_most(room, 12));
					else
						len = $urandom_range(0, 511);
					tails = (len == 0) ? 0 : len - 1;
					if (tails > 40) tails = $urandom_range(0, 4);
					if ($urandom_range(0, 7) == 0) tails += $urandom_range(1, 3);
					it.action       = ACT_BAPPEND;
					it.block_first  = 1'b1;
					it.block_length = 9'(len);
					send_request(it);
					sent++;
					for (k = 0; k < tails; k++) begin
						it = noise_item();
						it.action      = ACT_BAPPEND;
						it.block_first = 1'b0;
						send_request(it);
						sent++;
					end
					continue;
				end else if (pick < 88) begin
					// Block peek inside the fill most of the time; keep the
					// random offset and size otherwise.
					it.action = ACT_BPEEK;
					if (cnt != 0 && $urandom_range(0, 4) != 0) begin
						it.amount = ($urandom_range(0, 1) != 0) ? 8'd0 :
							8'($urandom_range(0, at_most(cnt - 1, 255)));
						avail = cnt - it.amount;
						if (avail >= MAX_PEEK && $urandom_range(0, 3) == 0)
							it.peek_size = 7'($urandom_range(MAX_PEEK + 1, 127));
						else
							it.peek_size = 7'($urandom_range(0, at_most(avail, MAX_PEEK)));
					end
				end else if (pick < 92) begin
					// stray block element with no head in front of it
					it.action      = ACT_BAPPEND;
					it.block_first = 1'b0;
				end else if (pick < 95) begin
					it.action = ($urandom_range(0, 1) != 0) ? ACT_SPARE7 : ACT_SPARE6;
				end
				// otherwise leave the request fully random
				send_request(it);
				sent++;
			end
		end

		// Wait out every due response, then a few cycles for anything stray.
		req_ch.valid <= 1'b0;
		while (shadow.due_rsp.size() != 0) @(negedge clk);
		repeat (20) @(posedge clk);

		$display("%0d requests, %0d responses checked over %0d capacity settings",
			shadow.requests, shadow.responses, settings);
		$display("%0d mismatches", shadow.mismatches);
		if (shadow.mismatches == 0 && shadow.due_rsp.size() == 0)
			$display("[byte_ring_queue_with_peek] OK");
		else
			$display("[byte_ring_queue_with_peek] ERROR");
		$finish;
	end

endmodule

// File: byte_ring_queue_with_peek.f
rtl/brq_pkg.sv
rtl/brq_chan_if.sv
rtl/brq_ram.sv
rtl/byte_ring_queue_with_peek.sv
tb/testbench.sv
